// File: hw/rtl/ymhbc_pkg.sv
// Shared constants for the Ymodem header block checker.
// Holds frame geometry, protocol codes, CRC constants and verdict codes.
// Depends on nothing.
`default_nettype none

package ymhbc_pkg;

    localparam int FRAME_BYTES = 133;
    localparam int NAME_LIMIT  = 13;

    localparam int CNT_W     = $clog2(FRAME_BYTES + 1);
    localparam int NAME_LEN_W = $clog2(NAME_LIMIT + 2);
    localparam int NAME_IDX_W = (NAME_LIMIT > 1) ? $clog2(NAME_LIMIT) : 1;

    localparam logic [CNT_W-1:0] POS_LEAD     = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_BLOCK    = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_INVERSE  = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_CRC_HI   = CNT_W'(FRAME_BYTES - 2);
    localparam logic [CNT_W-1:0] POS_CRC_LO   = CNT_W'(FRAME_BYTES - 1);
    localparam logic [CNT_W-1:0] FRAME_COUNT  = CNT_W'(FRAME_BYTES);

    localparam logic [NAME_LEN_W-1:0] NAME_MAX     = NAME_LEN_W'(NAME_LIMIT);
    localparam logic [NAME_LEN_W-1:0] NAME_OVERRUN = NAME_LEN_W'(NAME_LIMIT + 1);

    localparam logic [7:0] SOH_CODE = 8'h01;
    localparam logic [7:0] EOT_CODE = 8'h04;
    localparam logic [7:0] BLOCK_SUM = 8'hff;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam logic [7:0] TIMEOUT_RESET = 8'd10;

    localparam logic [2:0] V_EOT       = 3'd0;
    localparam logic [2:0] V_BATCH_END = 3'd1;
    localparam logic [2:0] V_NAME      = 3'd2;
    localparam logic [2:0] V_TOO_LONG  = 3'd3;
    localparam logic [2:0] V_BAD       = 3'd4;

endpackage

`default_nettype wire

// File: hw/rtl/ymodem_header_block_checker_unit.sv
// Ymodem header block checker: collects one header frame, checks it and streams a verdict.
// A data byte runs through a bit-serial CRC-16 shifter, one bit per cycle.
// Depends on ymhbc_pkg.
// A data byte is accepted, then the input is held while the CRC shifter works through its bits;
// header, CRC and timeout beats are accepted without a hold. A closing beat moves to an
// evaluation state and then emits the result beats (1 to 13 beats), subject to output stall.
// The single bit-serial CRC shifter sets the data byte rate: no new byte is taken while it shifts.
// Reset is synchronous, active low; it clears frame state and sets the timeout limit to 10.
`default_nettype none

module ymodem_header_block_checker_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wen,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  wire logic        i_s_tuser,   // [0] command
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [2:0] verdict, [10:3] name_byte, [15:11] zero
    output logic             o_m_tlast
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CRC   = 2'd1;
    localparam logic [1:0] S_CLOSE = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    localparam int CW = ymhbc_pkg::CNT_W;
    localparam int LW = ymhbc_pkg::NAME_LEN_W;
    localparam int IW = ymhbc_pkg::NAME_IDX_W;

    logic [1:0]    r_state, n_state;
    logic [7:0]    r_limit, n_limit;
    logic [CW-1:0] r_byte_count, n_byte_count;
    logic [7:0]    r_timeout_count, n_timeout_count;
    logic [7:0]    r_lead, n_lead;
    logic [7:0]    r_block, n_block;
    logic [7:0]    r_inverse, n_inverse;
    logic [15:0]   r_crc, n_crc;
    logic [15:0]   r_sent_crc, n_sent_crc;
    logic [LW-1:0] r_name_len, n_name_len;
    logic          r_name_closed, n_name_closed;
    logic [2:0]    r_bit, n_bit;
    logic [2:0]    r_kind, n_kind;
    logic [LW-1:0] r_emit_len, n_emit_len;
    logic [LW-1:0] r_emit_idx, n_emit_idx;
    logic          r_out_valid, n_out_valid;
    logic [2:0]    r_out_verdict;
    logic [7:0]    r_out_name;
    logic          r_out_last;
    logic [7:0]    r_name_store [ymhbc_pkg::NAME_LIMIT];

    logic          w_accept;
    logic          w_load;
    logic          w_store_we;
    logic          w_is_data;
    logic [CW-1:0] w_count_inc;
    logic [7:0]    w_blk_sum;
    logic [15:0]   w_crc_shl;
    logic          w_beat_last;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load     = (r_state == S_EMIT) && (!r_out_valid || i_m_tready);
    assign w_count_inc = r_byte_count + 1'b1;
    assign w_blk_sum  = r_block + r_inverse;
    assign w_crc_shl  = {r_crc[14:0], 1'b0};
    assign w_is_data  = (r_byte_count > ymhbc_pkg::POS_INVERSE)
                        && (r_byte_count < ymhbc_pkg::POS_CRC_HI);
    assign w_beat_last = (r_emit_idx + 1'b1) == r_emit_len;
    assign w_store_we = w_accept && !i_s_tuser && w_is_data && !r_name_closed
                        && (i_s_tdata != 8'd0) && (r_name_len < ymhbc_pkg::NAME_MAX);

    always_comb begin
        n_state         = r_state;
        n_limit         = i_cfg_wen ? i_cfg_wdata : r_limit;
        n_byte_count    = r_byte_count;
        n_timeout_count = r_timeout_count;
        n_lead          = r_lead;
        n_block         = r_block;
        n_inverse       = r_inverse;
        n_crc           = r_crc;
        n_sent_crc      = r_sent_crc;
        n_name_len      = r_name_len;
        n_name_closed   = r_name_closed;
        n_bit           = r_bit;
        n_kind          = r_kind;
        n_emit_len      = r_emit_len;
        n_emit_idx      = r_emit_idx;
        n_out_valid     = r_out_valid;
        if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser) begin
                        n_timeout_count = r_timeout_count + 1'b1;
                        if (n_timeout_count >= r_limit) begin
                            n_state = S_CLOSE;
                        end
                    end else begin
                        n_byte_count = w_count_inc;
                        if (r_byte_count == ymhbc_pkg::POS_LEAD) begin
                            n_lead = i_s_tdata;
                        end else if (r_byte_count == ymhbc_pkg::POS_BLOCK) begin
                            n_block = i_s_tdata;
                        end else if (r_byte_count == ymhbc_pkg::POS_INVERSE) begin
                            n_inverse = i_s_tdata;
                        end else if (r_byte_count == ymhbc_pkg::POS_CRC_HI) begin
                            n_sent_crc = {i_s_tdata, r_sent_crc[7:0]};
                        end else if (r_byte_count == ymhbc_pkg::POS_CRC_LO) begin
                            n_sent_crc = {r_sent_crc[15:8], i_s_tdata};
                        end else begin
                            n_crc = r_crc ^ {i_s_tdata, 8'h00};
                            n_bit = 3'd0;
                            n_state = S_CRC;
                            if (!r_name_closed) begin
                                if (i_s_tdata == 8'd0) begin
                                    n_name_closed = 1'b1;
                                end else if (r_name_len < ymhbc_pkg::NAME_MAX) begin
                                    n_name_len = r_name_len + 1'b1;
                                end else begin
                                    n_name_len    = ymhbc_pkg::NAME_OVERRUN;
                                    n_name_closed = 1'b1;
                                end
                            end
                        end
                        if (w_count_inc >= ymhbc_pkg::FRAME_COUNT) begin
                            n_state = S_CLOSE;
                        end
                    end
                end
            end
            S_CRC: begin
                n_crc = ((r_crc & ymhbc_pkg::CRC_TOP) != 16'd0)
                        ? (w_crc_shl ^ ymhbc_pkg::CRC_POLY) : w_crc_shl;
                n_bit = r_bit + 1'b1;
                if (r_bit == 3'd7) begin
                    n_state = S_IDLE;
                end
            end
            S_CLOSE: begin
                n_emit_len = LW'(1);
                if ((r_byte_count != '0) && (r_lead == ymhbc_pkg::EOT_CODE)) begin
                    n_kind = ymhbc_pkg::V_EOT;
                end else if ((r_byte_count < ymhbc_pkg::FRAME_COUNT)
                             || (r_lead != ymhbc_pkg::SOH_CODE)
                             || (w_blk_sum != ymhbc_pkg::BLOCK_SUM)
                             || (r_crc != r_sent_crc)) begin
                    n_kind = ymhbc_pkg::V_BAD;
                end else if (!r_name_closed || (r_name_len > ymhbc_pkg::NAME_MAX)) begin
                    n_kind = ymhbc_pkg::V_TOO_LONG;
                end else if (r_name_len == '0) begin
                    n_kind = ymhbc_pkg::V_BATCH_END;
                end else begin
                    n_kind     = ymhbc_pkg::V_NAME;
                    n_emit_len = r_name_len;
                end
                n_emit_idx      = '0;
                n_byte_count    = '0;
                n_timeout_count = 8'd0;
                n_lead          = 8'd0;
                n_block         = 8'd0;
                n_inverse       = 8'd0;
                n_crc           = 16'd0;
                n_sent_crc      = 16'd0;
                n_name_len      = '0;
                n_name_closed   = 1'b0;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_emit_idx  = r_emit_idx + 1'b1;
                    if (w_beat_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_limit         <= ymhbc_pkg::TIMEOUT_RESET;
            r_byte_count    <= '0;
            r_timeout_count <= 8'd0;
            r_lead          <= 8'd0;
            r_block         <= 8'd0;
            r_inverse       <= 8'd0;
            r_crc           <= 16'd0;
            r_sent_crc      <= 16'd0;
            r_name_len      <= '0;
            r_name_closed   <= 1'b0;
            r_bit           <= 3'd0;
            r_kind          <= ymhbc_pkg::V_BAD;
            r_emit_len      <= '0;
            r_emit_idx      <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_limit         <= n_limit;
            r_byte_count    <= n_byte_count;
            r_timeout_count <= n_timeout_count;
            r_lead          <= n_lead;
            r_block         <= n_block;
            r_inverse       <= n_inverse;
            r_crc           <= n_crc;
            r_sent_crc      <= n_sent_crc;
            r_name_len      <= n_name_len;
            r_name_closed   <= n_name_closed;
            r_bit           <= n_bit;
            r_kind          <= n_kind;
            r_emit_len      <= n_emit_len;
            r_emit_idx      <= n_emit_idx;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_name_store[r_name_len[IW-1:0]] <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_verdict <= r_kind;
            r_out_name    <= (r_kind == ymhbc_pkg::V_NAME)
                             ? r_name_store[r_emit_idx[IW-1:0]] : 8'd0;
            r_out_last    <= w_beat_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_name, r_out_verdict};
    assign o_m_tlast  = r_out_last;

    a_single_beat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[2:0] != ymhbc_pkg::V_NAME)) |-> o_m_tlast)
        else $error("Non-name verdict beat without tlast.");

    a_name_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[2:0] != ymhbc_pkg::V_NAME)) |-> (o_m_tdata[10:3] == 8'd0))
        else $error("Name byte set on a non-name verdict beat.");

    a_name_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_name_len <= ymhbc_pkg::NAME_OVERRUN)
        && (!r_name_closed || (r_name_len != ymhbc_pkg::NAME_OVERRUN) || r_name_closed))
        else $error("Name length beyond its overrun mark.");

    a_crc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRC && r_bit != 3'd7) |=> (r_state == S_CRC))
        else $error("CRC shift sequence cut short.");

endmodule

`default_nettype wire
